// ===== rtl/drd_pkg.sv =====
// ----------------------------------------------------------------------------
// drd_pkg: shared types and constants for the detection row decoder
// Row layout constants, register indexes and the 16 bit saturation helper.
// ----------------------------------------------------------------------------
package drd_pkg;

	// row layout: four box fields, objectness, then class scores
	localparam int BOX_FIELDS  = 4;
	localparam int HEAD_FIELDS = 5;
	localparam int MAX_CLASSES = 255;
	localparam int MAX_ROWS    = 32768;
	localparam int CONF_MAX    = 65536;

	localparam int POS_W  = 9;
	localparam int ROW_W  = 15;
	localparam int CLS_W  = 8;
	localparam int CONF_W = 17;
	localparam int BOX_W  = 16;
	localparam int VAL_W  = 32;
	localparam int CFG_W  = 27;

	typedef enum logic [2:0] {
		REG_CLASS_COUNT,
		REG_COEFF_COUNT,
		REG_BOX_THRESHOLD,
		REG_CLASS_THRESHOLD,
		REG_PAD_X,
		REG_PAD_Y,
		REG_SCALE_X,
		REG_SCALE_Y
	} cfg_reg_t;

	function automatic logic signed [BOX_W-1:0] sat16(input logic signed [31:0] v);
		logic signed [BOX_W-1:0] r;
		if (v > 32'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -32'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[BOX_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/detection_row_decoder_top.sv =====
// ----------------------------------------------------------------------------
// detection_row_decoder_top
// Streams a detector's prediction rows one Q16.16 value per word, tracks the
// box, objectness and running argmax of each row, and emits one detection
// word per kept row with confidence and the box mapped to source pixels.
// ----------------------------------------------------------------------------
//  channel  | signals                                          | direction
//  ---------+--------------------------------------------------+----------
//  in       | in_valid, in_ready, value, frame_start           | sink
//  out      | out_valid, out_ready, row_index, class_id,       | source
//           | confidence, box_left, box_top, box_width,        |
//           | box_height                                       |
//  cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data        | sink
//
//  one input word a cycle while in_ready is high; for a kept row,
//  stage one captures the row at its last word, stage two holds the
//  multipliers and saturation, then the output register
//  in_ready drops only while a kept row waits in stage one behind a full,
//  stalled output register
//  arst_n clears the position, row counter, argmax class and all valid flags
//  cfg_ready is always high; registers take their documented reset values
module detection_row_decoder_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [drd_pkg::VAL_W-1:0]      value,
	input  logic                                  frame_start,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic        [drd_pkg::ROW_W-1:0]      row_index,
	output logic        [drd_pkg::CLS_W-1:0]      class_id,
	output logic        [drd_pkg::CONF_W-1:0]     confidence,
	output logic signed [drd_pkg::BOX_W-1:0]      box_left,
	output logic signed [drd_pkg::BOX_W-1:0]      box_top,
	output logic signed [drd_pkg::BOX_W-1:0]      box_width,
	output logic signed [drd_pkg::BOX_W-1:0]      box_height,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic        [2:0]                     cfg_index,
	input  logic        [drd_pkg::CFG_W-1:0]      cfg_data
);
	import drd_pkg::*;

	// configuration registers
	logic [7:0]  class_count_q;
	logic [6:0]  coeff_count_q;
	logic [16:0] box_thr_q;
	logic [16:0] cls_thr_q;
	logic [26:0] pad_x_q;
	logic [26:0] pad_y_q;
	logic [22:0] scale_x_q;
	logic [22:0] scale_y_q;

	// row state
	logic [POS_W-1:0] pos_q;
	logic [ROW_W-1:0] row_q;
	logic [VAL_W-1:0] box_q [BOX_FIELDS];
	logic [VAL_W-1:0] obj_q;
	logic [VAL_W-1:0] best_q;
	logic [CLS_W-1:0] class_q;

	// stage one: snapshot of a finished row
	logic                valid_s1;
	logic [ROW_W-1:0]    row_s1;
	logic [CLS_W-1:0]    class_s1;
	logic [VAL_W-1:0]    obj_s1;
	logic [VAL_W-1:0]    best_s1;
	logic signed [34:0]  tx_s1;
	logic signed [34:0]  ty_s1;
	logic signed [31:0]  w_s1;
	logic signed [31:0]  h_s1;

	// output register
	logic out_valid_q;

	logic                in_acc;
	logic [7:0]          classes;
	logic [POS_W-1:0]    pos_now;
	logic [POS_W-1:0]    last_pos;
	logic [POS_W-1:0]    class_end;
	logic [POS_W-1:0]    cls_idx;
	logic [ROW_W-1:0]    row_now;
	logic                row_end;
	logic                in_class;
	logic                take_best;
	logic [VAL_W-1:0]    best_next;
	logic [CLS_W-1:0]    class_next;
	logic [ROW_W:0]      row_inc;
	logic [ROW_W-1:0]    row_next;
	logic signed [34:0]  tx_now;
	logic signed [34:0]  ty_now;

	logic keep_s1;
	logic out_free;
	logic s1_drain;
	logic load_out;

	logic [63:0]         conf_prod;
	logic [47:0]         conf_shift;
	logic [CONF_W-1:0]   conf_sat;
	logic signed [58:0]  px;
	logic signed [58:0]  py;
	logic signed [58:0]  px_adj;
	logic signed [58:0]  py_adj;
	logic signed [55:0]  pw;
	logic signed [55:0]  ph;
	logic signed [55:0]  pw_adj;
	logic signed [55:0]  ph_adj;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_count_q <= 8'd80;
			coeff_count_q <= 7'd32;
			box_thr_q     <= 17'd16384;
			cls_thr_q     <= 17'd16384;
			pad_x_q       <= '0;
			pad_y_q       <= '0;
			scale_x_q     <= 23'd65536;
			scale_y_q     <= 23'd65536;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_CLASS_COUNT:     class_count_q <= cfg_data[7:0];
				REG_COEFF_COUNT:     coeff_count_q <= cfg_data[6:0];
				REG_BOX_THRESHOLD:   box_thr_q     <= cfg_data[16:0];
				REG_CLASS_THRESHOLD: cls_thr_q     <= cfg_data[16:0];
				REG_PAD_X:           pad_x_q       <= cfg_data;
				REG_PAD_Y:           pad_y_q       <= cfg_data;
				REG_SCALE_X:         scale_x_q     <= cfg_data[22:0];
				REG_SCALE_Y:         scale_y_q     <= cfg_data[22:0];
				default: ;
			endcase
		end
	end

	// ---------------- word intake and row tracking ----------------
	always_comb begin
		if (class_count_q == 8'd0) begin
			classes = 8'd1;
		end else if (class_count_q > 8'(MAX_CLASSES)) begin
			classes = 8'(MAX_CLASSES);
		end else begin
			classes = class_count_q;
		end
		pos_now   = frame_start ? '0 : pos_q;
		row_now   = frame_start ? '0 : row_q;
		class_end = POS_W'(HEAD_FIELDS) + {1'b0, classes};
		last_pos  = class_end + {2'b00, coeff_count_q} - POS_W'(1);
		row_end   = pos_now >= last_pos;
		in_class  = (pos_now >= POS_W'(HEAD_FIELDS)) && (pos_now < class_end);
		cls_idx   = pos_now - POS_W'(HEAD_FIELDS);
		// first class score always loads, later ones only on a strict win
		take_best = in_class && ((cls_idx == '0) || ($signed(value) > $signed(best_q)));
		best_next  = take_best ? value : best_q;
		class_next = take_best ? cls_idx[CLS_W-1:0] : class_q;
		row_inc   = {1'b0, row_now} + (ROW_W+1)'(1);
		if ({1'b0, row_inc} >= 17'(MAX_ROWS) || row_inc[ROW_W]) begin
			row_next = '0;
		end else begin
			row_next = row_inc[ROW_W-1:0];
		end
		// twice the left or top edge, relative to the padding
		tx_now = $signed({{2{box_q[0][31]}}, box_q[0], 1'b0})
			- $signed({7'b0, pad_x_q, 1'b0})
			- $signed({{3{box_q[2][31]}}, box_q[2]});
		ty_now = $signed({{2{box_q[1][31]}}, box_q[1], 1'b0})
			- $signed({7'b0, pad_y_q, 1'b0})
			- $signed({{3{box_q[3][31]}}, box_q[3]});
	end

	assign keep_s1  = ($signed(obj_s1) >= $signed({15'b0, box_thr_q}))
		&& ($signed(best_s1) >= $signed({15'b0, cls_thr_q}));
	assign out_free = !out_valid_q || out_ready;
	assign s1_drain = !keep_s1 || out_free;
	assign load_out = valid_s1 && keep_s1 && out_free;
	assign in_ready = !valid_s1 || s1_drain;
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			row_q   <= '0;
			class_q <= '0;
		end else if (in_acc) begin
			class_q <= class_next;
			if (row_end) begin
				pos_q <= '0;
				row_q <= row_next;
			end else begin
				pos_q <= pos_now + POS_W'(1);
				row_q <= row_now;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (pos_now < POS_W'(BOX_FIELDS)) begin
				box_q[pos_now[1:0]] <= value;
			end
			if (pos_now == POS_W'(BOX_FIELDS)) begin
				obj_q <= value;
			end
			best_q <= best_next;
		end
	end

	// ---------------- stage one ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc && row_end) begin
			valid_s1 <= 1'b1;
		end else if (s1_drain) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && row_end) begin
			row_s1   <= row_now;
			class_s1 <= class_next;
			obj_s1   <= obj_q;
			best_s1  <= best_next;
			tx_s1    <= tx_now;
			ty_s1    <= ty_now;
			w_s1     <= $signed(box_q[2]);
			h_s1     <= $signed(box_q[3]);
		end
	end

	// ---------------- stage two: products and saturation ----------------
	assign conf_prod  = obj_s1 * best_s1;
	assign conf_shift = conf_prod[63:16];
	assign conf_sat   = (conf_shift > 48'(CONF_MAX)) ? CONF_W'(CONF_MAX)
		: conf_shift[CONF_W-1:0];

	// truncation toward zero: bias negative products before the shift
	assign px     = tx_s1 * $signed({1'b0, scale_x_q});
	assign py     = ty_s1 * $signed({1'b0, scale_y_q});
	assign px_adj = px + (px[58] ? 59'sh1_ffff_ffff : 59'sd0);
	assign py_adj = py + (py[58] ? 59'sh1_ffff_ffff : 59'sd0);
	assign pw     = w_s1 * $signed({1'b0, scale_x_q});
	assign ph     = h_s1 * $signed({1'b0, scale_y_q});
	assign pw_adj = pw + (pw[55] ? 56'sh0_ffff_ffff : 56'sd0);
	assign ph_adj = ph + (ph[55] ? 56'sh0_ffff_ffff : 56'sd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			row_index  <= row_s1;
			class_id   <= class_s1;
			confidence <= conf_sat;
			box_left   <= sat16($signed({{6{px_adj[58]}}, px_adj[58:33]}));
			box_top    <= sat16($signed({{6{py_adj[58]}}, py_adj[58:33]}));
			box_width  <= sat16($signed({{8{pw_adj[55]}}, pw_adj[55:32]}));
			box_height <= sat16($signed({{8{ph_adj[55]}}, ph_adj[55:32]}));
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_row_end_loads_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && row_end |=> valid_s1)
		else $error("finished row not captured in stage one");

	a_stall_only_on_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && keep_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a blocked detection");

	a_out_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s1) && $past(keep_s1))
		else $error("detection word without a kept row");

	a_conf_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> confidence <= 17'd65536)
		else $error("confidence above saturation limit");
`endif

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: detection row decoder
// Streams prediction rows into the decoder under random handshake gaps and
// checks every detection word against an in-bench decoder of the same rows.
// A random run under reset settings and a short scripted frame come first, then
// rows with random content under a range of register settings and a long output stall.
// ----------------------------------------------------------------------------
module testbench;
	import drd_pkg::*;

	localparam int DRAIN_CYCLES = 8;
	localparam int STALL_LIMIT  = 5000;

	typedef struct packed {
		logic        [ROW_W-1:0]  row_index;
		logic        [CLS_W-1:0]  class_id;
		logic        [CONF_W-1:0] confidence;
		logic signed [BOX_W-1:0]  box_left;
		logic signed [BOX_W-1:0]  box_top;
		logic signed [BOX_W-1:0]  box_width;
		logic signed [BOX_W-1:0]  box_height;
	} detection_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] v;
		logic                    fs;
		logic                    has_det;
		detection_t              det;
	} script_word_t;

	localparam detection_t NO_DET = '0;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic signed [VAL_W-1:0]  value;
	logic                     frame_start;
	logic                     out_valid;
	logic                     out_ready;
	logic        [ROW_W-1:0]  row_index;
	logic        [CLS_W-1:0]  class_id;
	logic        [CONF_W-1:0] confidence;
	logic signed [BOX_W-1:0]  box_left;
	logic signed [BOX_W-1:0]  box_top;
	logic signed [BOX_W-1:0]  box_width;
	logic signed [BOX_W-1:0]  box_height;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic        [2:0]        cfg_index;
	logic        [CFG_W-1:0]  cfg_data;

	// decoder copy: register settings
	logic [7:0]  cls_cnt   = 8'd80;
	logic [6:0]  coef_cnt  = 7'd32;
	logic [16:0] obj_thr   = 17'd16384;
	logic [16:0] score_thr = 17'd16384;
	logic [26:0] pad_h     = '0;
	logic [26:0] pad_v     = '0;
	logic [22:0] scl_h     = 23'd65536;
	logic [22:0] scl_v     = 23'd65536;

	// decoder copy: row state
	int                      dec_pos = 0;
	int                      dec_row = 0;
	logic signed [VAL_W-1:0] dec_box [BOX_FIELDS];
	logic signed [VAL_W-1:0] dec_obj  = '0;
	logic signed [VAL_W-1:0] dec_best = '0;
	logic        [7:0]       dec_cls  = '0;

	detection_t due_detections [$];
	int         mismatches = 0;
	bit         no_idle    = 1'b0;
	int         hold_left  = 0;
	int         rx_stall   = 0;
	int         idle_cycles;

	// one frame of four rows: two classes, no coefficients, thresholds at 0.5
	script_word_t directed_words [28] = '{
		'{32'sd6553600, 1'b1, 1'b0, NO_DET},
		'{32'sd3276800, 1'b0, 1'b0, NO_DET},
		'{32'sd1310720, 1'b0, 1'b0, NO_DET},
		'{32'sd655360,  1'b0, 1'b0, NO_DET},
		'{32'sd65536,   1'b0, 1'b0, NO_DET},
		'{32'sd49152,   1'b0, 1'b0, NO_DET},
		'{32'sd65536,   1'b0, 1'b1,
			'{15'd0, 8'd1, 17'd65536, 16'sd90, 16'sd45, 16'sd20, 16'sd10}},
		// scores tie at exactly the threshold: first class wins
		'{32'sd0,       1'b0, 1'b0, NO_DET},
		'{32'sd0,       1'b0, 1'b0, NO_DET},
		'{32'sd0,       1'b0, 1'b0, NO_DET},
		'{32'sd0,       1'b0, 1'b0, NO_DET},
		'{32'sd32768,   1'b0, 1'b0, NO_DET},
		'{32'sd32768,   1'b0, 1'b0, NO_DET},
		'{32'sd32768,   1'b0, 1'b1,
			'{15'd1, 8'd0, 17'd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0}},
		// objectness one lsb short, negative first score
		'{32'sh01234567, 1'b0, 1'b0, NO_DET},
		'{-32'sd65536,  1'b0, 1'b0, NO_DET},
		'{32'sd0,       1'b0, 1'b0, NO_DET},
		'{32'sd1,       1'b0, 1'b0, NO_DET},
		'{32'sd32767,   1'b0, 1'b0, NO_DET},
		'{-32'sd1,      1'b0, 1'b0, NO_DET},
		'{32'sh7fffffff, 1'b0, 1'b0, NO_DET},
		// value extremes, confidence saturates
		'{32'sh7fffffff, 1'b0, 1'b0, NO_DET},
		'{32'sh80000000, 1'b0, 1'b0, NO_DET},
		'{32'sh7fffffff, 1'b0, 1'b0, NO_DET},
		'{32'sh80000000, 1'b0, 1'b0, NO_DET},
		'{32'sh7fffffff, 1'b0, 1'b0, NO_DET},
		'{32'sh80000000, 1'b0, 1'b0, NO_DET},
		'{32'sh7fffffff, 1'b0, 1'b1,
			'{15'd3, 8'd1, 17'd65536, 16'sd16383, -16'sd16384, 16'sd32767, 16'sh8000}}
	};

	detection_row_decoder_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.value       (value),
		.frame_start (frame_start),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.row_index   (row_index),
		.class_id    (class_id),
		.confidence  (confidence),
		.box_left    (box_left),
		.box_top     (box_top),
		.box_width   (box_width),
		.box_height  (box_height),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic signed [BOX_W-1:0] clip_px(input longint x);
		if (x > 32767) begin
			return 16'sh7fff;
		end
		if (x < -32768) begin
			return 16'sh8000;
		end
		return x[BOX_W-1:0];
	endfunction

	// exact in Q16.16: trunc((2c - 2pad - s) * scale / 2^33)
	function automatic logic signed [BOX_W-1:0] box_edge(input logic signed [31:0] c,
		input logic signed [31:0] s, input logic [26:0] pad, input logic [22:0] scale);
		longint twice;
		twice = 2 * longint'(c) - 2 * longint'(pad) - longint'(s);
		return clip_px((twice * longint'(scale)) / (longint'(1) <<< 33));
	endfunction

	function automatic logic signed [BOX_W-1:0] box_extent(input logic signed [31:0] s,
		input logic [22:0] scale);
		return clip_px((longint'(s) * longint'(scale)) / (longint'(1) <<< 32));
	endfunction

	task automatic queue_detection(input detection_t d);
		due_detections = {due_detections, d};
	endtask

	task automatic decode_word(input logic signed [31:0] v, input logic fs,
		output bit kept, output detection_t det);
		int     classes;
		int     last;
		int     p;
		longint conf;
		classes = (cls_cnt == 0) ? 1 : int'(cls_cnt);
		if (classes > MAX_CLASSES) begin
			classes = MAX_CLASSES;
		end
		last = HEAD_FIELDS + classes + int'(coef_cnt) - 1;
		kept = 1'b0;
		det = '0;
		if (fs) begin
			dec_pos = 0;
			dec_row = 0;
		end
		p = dec_pos;
		if (p < BOX_FIELDS) begin
			dec_box[p] = v;
		end else if (p == BOX_FIELDS) begin
			dec_obj = v;
		end else if (p < HEAD_FIELDS + classes) begin
			if (p == HEAD_FIELDS || v > dec_best) begin
				dec_best = v;
				dec_cls = 8'(p - HEAD_FIELDS);
			end
		end
		// a row also ends early when a smaller setting lands mid-row
		if (p >= last) begin
			if (longint'(dec_obj) >= longint'(obj_thr) &&
					longint'(dec_best) >= longint'(score_thr)) begin
				conf = (longint'(dec_obj) * longint'(dec_best)) >>> 16;
				if (conf > CONF_MAX) begin
					conf = CONF_MAX;
				end
				det.row_index  = 15'(dec_row);
				det.class_id   = dec_cls;
				det.confidence = 17'(conf);
				det.box_left   = box_edge(dec_box[0], dec_box[2], pad_h, scl_h);
				det.box_top    = box_edge(dec_box[1], dec_box[3], pad_v, scl_v);
				det.box_width  = box_extent(dec_box[2], scl_h);
				det.box_height = box_extent(dec_box[3], scl_v);
				kept = 1'b1;
			end
			dec_row++;
			if (dec_row >= MAX_ROWS || dec_row > 32767) begin
				dec_row = 0;
			end
			dec_pos = 0;
		end else begin
			dec_pos = (p + 1) % 512;
		end
	endtask

	function automatic logic signed [31:0] near_level(input int unsigned thr);
		logic signed [31:0] r;
		case ($urandom_range(0, 7))
			0: r = $urandom;
			1: r = thr - 1;
			2: r = thr;
			default: r = $urandom_range(0, thr * 2 + 256);
		endcase
		return r;
	endfunction

	// content suited to the position the next word lands on
	function automatic logic signed [31:0] pick_value();
		logic signed [31:0] r;
		int                 classes;
		classes = (cls_cnt == 0) ? 1 : int'(cls_cnt);
		if ($urandom_range(0, 11) == 0 || dec_pos >= HEAD_FIELDS + classes) begin
			r = $urandom;
		end else if (dec_pos < BOX_FIELDS) begin
			if ($urandom_range(0, 5) == 0) begin
				r = $urandom;
			end else begin
				r = $urandom_range(0, 32'h0400_0000);
				if ($urandom_range(0, 3) == 0) begin
					r = -r;
				end
			end
		end else if (dec_pos == BOX_FIELDS) begin
			r = near_level(32'(obj_thr));
		end else begin
			r = near_level(32'(score_thr));
		end
		return r;
	endfunction

	task automatic feed_word(input logic signed [31:0] v, input logic fs,
		input logic use_fixed, input detection_t fixed_det);
		int         gap;
		bit         kept;
		detection_t det;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid    <= 1'b1;
		value       <= v;
		frame_start <= fs;
		do @(posedge clk); while (!in_ready);
		decode_word(v, fs, kept, det);
		if (use_fixed) begin
			queue_detection(fixed_det);
		end else if (kept) begin
			queue_detection(det);
		end
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [CFG_W-1:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		case (r)
			REG_CLASS_COUNT:     cls_cnt   = d[7:0];
			REG_COEFF_COUNT:     coef_cnt  = d[6:0];
			REG_BOX_THRESHOLD:   obj_thr   = d[16:0];
			REG_CLASS_THRESHOLD: score_thr = d[16:0];
			REG_PAD_X:           pad_h     = d[26:0];
			REG_PAD_Y:           pad_v     = d[26:0];
			REG_SCALE_X:         scl_h     = d[22:0];
			REG_SCALE_Y:         scl_v     = d[22:0];
			default: ;
		endcase
	endtask

	task automatic write_settings(input int unsigned cc, input int unsigned coef,
		input int unsigned bt, input int unsigned ct, input int unsigned px,
		input int unsigned py, input int unsigned sx, input int unsigned sy);
		write_reg(REG_CLASS_COUNT, CFG_W'(cc));
		write_reg(REG_COEFF_COUNT, CFG_W'(coef));
		write_reg(REG_BOX_THRESHOLD, CFG_W'(bt));
		write_reg(REG_CLASS_THRESHOLD, CFG_W'(ct));
		write_reg(REG_PAD_X, CFG_W'(px));
		write_reg(REG_PAD_Y, CFG_W'(py));
		write_reg(REG_SCALE_X, CFG_W'(sx));
		write_reg(REG_SCALE_Y, CFG_W'(sy));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// stop offering words until every detection is back, then let the pipe empty
	task automatic settle(input int extra);
		@(negedge clk);
		in_valid <= 1'b0;
		while (due_detections.size() != 0) begin
			@(posedge clk);
		end
		repeat (extra) @(posedge clk);
	endtask

	task automatic run_random(input int count, input bit quiet);
		no_idle = quiet;
		repeat (count) begin
			feed_word(pick_value(), $urandom_range(0, 499) == 0, 1'b0, NO_DET);
			if ($urandom_range(0, 199) == 0) begin
				settle(0);
			end
		end
		no_idle = 1'b0;
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		detection_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_detections.size() == 0) begin
				$error("detection word with none due: row %0d class %0d", row_index, class_id);
				mismatches++;
			end else begin
				want = due_detections.pop_front();
				check_field("row_index", longint'(want.row_index), longint'(row_index));
				check_field("class_id", longint'(want.class_id), longint'(class_id));
				check_field("confidence", longint'(want.confidence), longint'(confidence));
				check_field("box_left", longint'(want.box_left), longint'(box_left));
				check_field("box_top", longint'(want.box_top), longint'(box_top));
				check_field("box_width", longint'(want.box_width), longint'(box_width));
				check_field("box_height", longint'(want.box_height),
					longint'(box_height));
			end
			rx_stall = no_idle ? 0 : $urandom_range(0, 5);
		end
	end

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (rx_stall > 0) begin
				out_ready <= 1'b0;
				rx_stall--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
					(cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		value       = '0;
		frame_start = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = REG_CLASS_COUNT;
		cfg_data    = '0;
		foreach (dec_box[i]) begin
			dec_box[i] = '0;
		end
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// reset settings: long rows, ends part way through a row
		run_random(274, 1'b0);
		settle(DRAIN_CYCLES);
		write_settings(2, 0, 32768, 32768, 0, 0, 65536, 65536);
		foreach (directed_words[i]) begin
			feed_word(directed_words[i].v, directed_words[i].fs,
				directed_words[i].has_det, directed_words[i].det);
		end

		// extremes: zero class count, widest padding and scale
		settle(DRAIN_CYCLES);
		write_settings(0, 0, 0, 0, 32'h07ff_ffff, 0, 32'h007f_ffff, 0);
		run_random(150, 1'b0);
		settle(DRAIN_CYCLES);
		write_settings(255, 127, 0, 0, 67108864, 67108864, 4194304, 4194304);
		run_random(450, 1'b0);
		settle(DRAIN_CYCLES);
		write_settings(1, 64, 131071, 131071, 0, 32'h07ff_ffff, 0, 32'h007f_ffff);
		run_random(200, 1'b0);
		settle(DRAIN_CYCLES);
		write_settings(2, 0, 65536, 65536, 0, 0, 65536, 65536);
		run_random(100, 1'b0);

		repeat (6) begin
			settle(DRAIN_CYCLES);
			write_settings($urandom_range(1, 6), $urandom_range(0, 4),
				$urandom_range(0, 65536), $urandom_range(0, 65536),
				$urandom_range(0, 32'h0100_0000), $urandom_range(0, 32'h0100_0000),
				$urandom_range(16384, 4194304), $urandom_range(16384, 4194304));
			run_random(100, $urandom_range(0, 3) == 0);
		end

		// most rows kept while the output side holds off: the input must back up
		settle(DRAIN_CYCLES);
		write_settings(1, 0, 0, 0, 32'h00a0_0000, 32'h0050_0000, 98304, 49152);
		hold_left = 300;
		run_random(60, 1'b1);

		settle(DRAIN_CYCLES + 4);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
